@@ src/drq_pkg.sv @@
// ----------------------------------------------------------------------------
// drq_pkg
// Shared types and codes of the delayed release queue.
// ----------------------------------------------------------------------------
package drq_pkg;

  localparam int unsigned PAY_W   = 32;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 3;

  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_POLL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  localparam logic [STAT_W-1:0] STAT_ACCEPTED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_READY = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DELIVERED = 3'd4;
  localparam logic [STAT_W-1:0] STAT_TICKED    = 3'd5;

  typedef enum logic [1:0] {
    CLS_PUT,
    CLS_POLL,
    CLS_TICK,
    CLS_BAD
  } cls_e;

  typedef struct packed {
    cls_e               cls;
    logic [PAY_W-1:0]   payload;
    logic [DELAY_W-1:0] delay;
  } item_t;

endpackage

@@ src/drq_front.sv @@
// ----------------------------------------------------------------------------
// drq_front
// Accepts input transactions, classifies the operation and queues them.
// ----------------------------------------------------------------------------
module drq_front import drq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [PAY_W-1:0]   payload_i,
  input  logic [DELAY_W-1:0] delay_ticks_i,
  input  logic               pop_i,
  output logic               vld_o,
  output item_t              item_o
);

  item_t      buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      cls_item;

  always_comb begin
    cls_item.payload = payload_i;
    cls_item.delay   = delay_ticks_i;
    unique case (operation_i)
      OP_PUT:  cls_item.cls = CLS_PUT;
      OP_POLL: cls_item.cls = CLS_POLL;
      OP_TICK: cls_item.cls = CLS_TICK;
      default: cls_item.cls = CLS_BAD;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign vld_o      = (cnt_q != 2'd0);
  assign item_o     = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= cls_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

@@ src/drq_back.sv @@
// ----------------------------------------------------------------------------
// drq_back
// Carries out queued operations on the entry store and drives the result.
// ----------------------------------------------------------------------------
module drq_back import drq_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned TIME_WIDTH = 32,
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned OCC_W = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  item_t             item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [PAY_W-1:0]  payload_out_o,
  output logic [OCC_W-1:0]  occ_o
);

  localparam logic [TIME_WIDTH-1:0] HALF = {1'b1, {(TIME_WIDTH-1){1'b0}}};
  localparam logic [OCC_W-1:0]      CAP  = OCC_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_DUE, S_LRD, S_LWR
  } state_e;

  logic [TIME_WIDTH-1:0] rel_mem [CAPACITY];
  logic [PAY_W-1:0]      pay_mem [CAPACITY];
  logic [TAG_W-1:0]      tag_mem [CAPACITY];

  state_e                state_q;
  logic [IDX_W-1:0]      idx_q, best_idx_q;
  logic [OCC_W-1:0]      occ_q;
  logic [TIME_WIDTH-1:0] now_q, best_key_q, rd_rel_q;
  logic [TAG_W-1:0]      tag_q, best_age_q, rd_tag_q;
  logic [PAY_W-1:0]      best_pay_q, rd_pay_q, pay_q;
  logic [STAT_W-1:0]     stat_q;
  logic                  ovld_q;

  logic                  we;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [TIME_WIDTH-1:0] wrel, key, lag;
  logic [PAY_W-1:0]      wpay;
  logic [TAG_W-1:0]      wtag, age;
  logic [OCC_W-1:0]      last;
  logic                  better, due;

  assign pop_o = (state_q == S_IDLE) && vld_i && !ovld_q;
  assign last  = occ_q - OCC_W'(1);
  assign raddr = (state_q == S_LRD) ? last[IDX_W-1:0] : idx_q;
  assign key   = (rd_rel_q - now_q) ^ HALF;
  assign age   = tag_q - rd_tag_q;
  assign better = (idx_q == '0) || (key < best_key_q) ||
                  ((key == best_key_q) && (age > best_age_q));
  assign lag   = best_key_q ^ HALF;
  assign due   = (lag == '0) || lag[TIME_WIDTH-1];

  always_comb begin
    we    = 1'b0;
    waddr = occ_q[IDX_W-1:0];
    wrel  = now_q + TIME_WIDTH'(item_i.delay);
    wpay  = item_i.payload;
    wtag  = tag_q;
    if (pop_o && item_i.cls == CLS_PUT && occ_q != CAP) begin
      we = 1'b1;
    end else if (state_q == S_LWR) begin
      we    = 1'b1;
      waddr = best_idx_q;
      wrel  = rd_rel_q;
      wpay  = rd_pay_q;
      wtag  = rd_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      rel_mem[waddr] <= wrel;
      pay_mem[waddr] <= wpay;
      tag_mem[waddr] <= wtag;
    end
    rd_rel_q <= rel_mem[raddr];
    rd_pay_q <= pay_mem[raddr];
    rd_tag_q <= tag_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      best_idx_q <= '0;
      occ_q      <= '0;
      now_q      <= '0;
      tag_q      <= '0;
      best_key_q <= '0;
      best_age_q <= '0;
      best_pay_q <= '0;
      ovld_q     <= 1'b0;
      stat_q     <= STAT_ACCEPTED;
      pay_q      <= '0;
    end else begin
      if (ovld_q && !out_stall_i) ovld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            pay_q <= '0;
            unique case (item_i.cls)
              CLS_PUT: begin
                ovld_q <= 1'b1;
                if (occ_q == CAP) begin
                  stat_q <= STAT_FULL;
                end else begin
                  stat_q <= STAT_ACCEPTED;
                  occ_q  <= occ_q + OCC_W'(1);
                  tag_q  <= tag_q + TAG_W'(1);
                end
              end
              CLS_POLL: begin
                if (occ_q == '0) begin
                  ovld_q <= 1'b1;
                  stat_q <= STAT_EMPTY;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_READ;
                end
              end
              CLS_TICK: begin
                ovld_q <= 1'b1;
                stat_q <= STAT_TICKED;
                now_q  <= now_q + TIME_WIDTH'(1);
              end
              default: begin
                ovld_q <= 1'b1;
                stat_q <= STAT_NOT_READY;
              end
            endcase
          end
        end
        S_READ: state_q <= S_CMP;
        S_CMP: begin
          if (better) begin
            best_idx_q <= idx_q;
            best_key_q <= key;
            best_age_q <= age;
            best_pay_q <= rd_pay_q;
          end
          if (OCC_W'(idx_q) + OCC_W'(1) == occ_q) begin
            state_q <= S_DUE;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= S_READ;
          end
        end
        S_DUE: begin
          ovld_q <= 1'b1;
          if (due) begin
            stat_q  <= STAT_DELIVERED;
            pay_q   <= best_pay_q;
            state_q <= S_LRD;
          end else begin
            stat_q  <= STAT_NOT_READY;
            state_q <= S_IDLE;
          end
        end
        S_LRD: state_q <= S_LWR;
        S_LWR: begin
          occ_q   <= last;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = ovld_q;
  assign status_o      = stat_q;
  assign payload_out_o = pay_q;
  assign occ_o         = occ_q;

endmodule

@@ src/delayed_release_queue.sv @@
// ----------------------------------------------------------------------------
// delayed_release_queue
// Delay queue: put with release time, poll for the earliest due entry, tick.
// ----------------------------------------------------------------------------
// A two-entry input queue takes transactions while the executing side works.
// Put, tick and undefined operations are done in the idle state of the execution unit;
// a poll scans the stored entries one at a time through the single memory
// read port, each entry passing through a read state and a compare state.
// A new transaction is started only once the previous result has left the
// output register.
module delayed_release_queue import drq_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [PAY_W-1:0]   payload_i,
  input  logic [DELAY_W-1:0] delay_ticks_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [PAY_W-1:0]   payload_out_o
);

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);

  logic             q_pop;
  logic             q_vld;
  item_t            item;
  logic [OCC_W-1:0] occ;

  drq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .payload_i,
    .delay_ticks_i, .pop_i(q_pop), .vld_o(q_vld), .item_o(item)
  );

  drq_back #(.CAPACITY(CAPACITY), .TIME_WIDTH(TIME_WIDTH)) u_back (
    .clk_i, .rst_ni, .vld_i(q_vld), .item_i(item), .pop_o(q_pop),
    .out_valid_o, .out_stall_i, .status_o, .payload_out_o, .occ_o(occ)
  );

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OCC_W'(CAPACITY)) else $error("occupancy above capacity");

  a_pay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_DELIVERED |-> payload_out_o == '0)
    else $error("payload on non-delivered result");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= STAT_TICKED) else $error("bad status code");

  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_vld && !out_valid_o) else $error("pop without item");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delayed release queue: a directed table of
// corner transactions, then random put/poll/tick/undefined traffic with random idling
// and a long receiver hold-off; each result is checked against the table or a predictor.
// ----------------------------------------------------------------------------
module tb;
  import drq_pkg::*;

  localparam int unsigned CAP      = 16;
  localparam int unsigned N_RANDOM = 1400;
  localparam int unsigned DIR_MAX  = 64;
  localparam int unsigned EXP_MAX  = 4096;
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [PAY_W-1:0]   pay;
    logic [DELAY_W-1:0] dly;
    bit                 known;
    logic [STAT_W-1:0]  st;
    logic [PAY_W-1:0]   pout;
  } row_t;

  typedef struct {
    logic [STAT_W-1:0] st;
    logic [PAY_W-1:0]  pout;
  } reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [OP_W-1:0]    operation_i = OP_TICK;
  logic [PAY_W-1:0]   payload_i = '0;
  logic [DELAY_W-1:0] delay_ticks_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [STAT_W-1:0]  status_o;
  logic [PAY_W-1:0]   payload_out_o;

  delayed_release_queue u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0]      rel_time [CAP];
  logic [PAY_W-1:0] held_pay [CAP];
  logic [TAG_W-1:0] order_tag [CAP];
  int unsigned      fill;
  logic [31:0]      now_ticks;
  logic [TAG_W-1:0] tag_next;

  reply_t replies_due [EXP_MAX];
  int     exp_head;
  int     exp_tail;
  row_t   dir [DIR_MAX];
  int     n_dir;
  int     errors;
  bit     quiet;
  int     hold_left;
  bit     hold_done;
  int     sent;

  function automatic reply_t queue_step(logic [OP_W-1:0] op, logic [PAY_W-1:0] pay,
                                        logic [DELAY_W-1:0] dly);
    reply_t r;
    int unsigned best;
    logic [31:0] key, best_key, diff;
    logic [TAG_W-1:0] age, best_age;
    r.pout = '0;
    if (op == OP_PUT) begin
      if (fill >= CAP) begin
        r.st = STAT_FULL;
      end else begin
        rel_time[fill] = now_ticks + dly;
        held_pay[fill] = pay;
        order_tag[fill] = tag_next;
        tag_next++;
        fill++;
        r.st = STAT_ACCEPTED;
      end
    end else if (op == OP_POLL) begin
      if (fill == 0) begin
        r.st = STAT_EMPTY;
      end else begin
        best = 0;
        best_key = (rel_time[0] - now_ticks) ^ 32'h8000_0000;
        best_age = tag_next - order_tag[0];
        for (int unsigned i = 1; i < fill; i++) begin
          key = (rel_time[i] - now_ticks) ^ 32'h8000_0000;
          age = tag_next - order_tag[i];
          if (key < best_key || (key == best_key && age > best_age)) begin
            best = i;
            best_key = key;
            best_age = age;
          end
        end
        diff = rel_time[best] - now_ticks;
        if (diff != 0 && !diff[31]) begin
          r.st = STAT_NOT_READY;
        end else begin
          r.pout = held_pay[best];
          rel_time[best] = rel_time[fill-1];
          held_pay[best] = held_pay[fill-1];
          order_tag[best] = order_tag[fill-1];
          fill--;
          r.st = STAT_DELIVERED;
        end
      end
    end else if (op == OP_TICK) begin
      now_ticks++;
      r.st = STAT_TICKED;
    end else begin
      r.st = STAT_NOT_READY;
    end
    return r;
  endfunction

  function automatic void add_row(row_t rw);
    dir[n_dir] = rw;
    n_dir++;
  endfunction

  task automatic send(row_t rw);
    reply_t r;
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= rw.op;
    payload_i     <= rw.pay;
    delay_ticks_i <= rw.dly;
    do @(posedge clk_i); while (in_stall_o);
    r = queue_step(rw.op, rw.pay, rw.dly);
    if (rw.known) begin
      r.st = rw.st;
      r.pout = rw.pout;
    end
    replies_due[exp_tail] = r;
    exp_tail++;
    sent++;
  endtask

  // receiver: random stall, one long hold-off
  always @(posedge clk_i) begin
    if (!hold_done && sent == 300) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 23);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_head == exp_tail) begin
        $error("unexpected transaction: status %0d payload_out %h", status_o, payload_out_o);
        errors++;
      end else begin
        e = replies_due[exp_head];
        exp_head++;
        if (status_o !== e.st) begin
          $error("status: expected %0d, actual %0d", e.st, status_o);
          errors++;
        end
        if (payload_out_o !== e.pout) begin
          $error("payload_out: expected %h, actual %h", e.pout, payload_out_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    row_t rw;
    int unsigned pick;
    fill = 0;
    now_ticks = '0;
    tag_next = '0;
    errors = 0;
    quiet = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    sent = 0;
    exp_head = 0;
    exp_tail = 0;
    n_dir = 0;

    // corners with results known at a glance
    add_row('{OP_POLL, 32'h0, 16'h0, 1, STAT_EMPTY, 32'h0});
    add_row('{OP_UNDEF, 32'hFFFF_FFFF, 16'hFFFF, 1, STAT_NOT_READY, 32'h0});
    add_row('{OP_PUT, 32'hFFFF_FFFF, 16'hFFFF, 1, STAT_ACCEPTED, 32'h0});
    add_row('{OP_POLL, 32'h0, 16'h0, 1, STAT_NOT_READY, 32'h0});
    add_row('{OP_PUT, 32'h0, 16'h0, 1, STAT_ACCEPTED, 32'h0});
    add_row('{OP_PUT, 32'hA5A5_A5A5, 16'h0, 1, STAT_ACCEPTED, 32'h0});
    // equal release times leave oldest first
    add_row('{OP_POLL, 32'h0, 16'h0, 1, STAT_DELIVERED, 32'h0});
    add_row('{OP_POLL, 32'h0, 16'h0, 1, STAT_DELIVERED, 32'hA5A5_A5A5});
    add_row('{OP_TICK, 32'h0, 16'h0, 1, STAT_TICKED, 32'h0});
    for (int i = 0; i < CAP - 1; i++)
      add_row('{OP_PUT, 32'h5A5A_0000 + 32'(i), 16'(i % 3), 0, STAT_ACCEPTED, 32'h0});
    add_row('{OP_PUT, 32'h1234_5678, 16'h1, 1, STAT_FULL, 32'h0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < n_dir; i++) send(dir[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 700 && n < 900);
      pick = $urandom_range(99);
      rw.known = 0;
      rw.st = '0;
      rw.pout = '0;
      rw.pay = $urandom;
      if (pick < 3)       rw.op = OP_UNDEF;
      else if (pick < 43) rw.op = OP_PUT;
      else if (pick < 78) rw.op = OP_POLL;
      else                rw.op = OP_TICK;
      pick = $urandom_range(99);
      if (pick < 70)      rw.dly = 16'($urandom_range(6));
      else if (pick < 95) rw.dly = 16'($urandom_range(40));
      else                rw.dly = 16'($urandom);
      send(rw);
    end
    in_valid_i <= 1'b0;

    fork
      wait (exp_head == exp_tail);
      begin
        repeat (20000) @(posedge clk_i);
        errors++;
      end
    join_any
    disable fork;
    repeat (60) @(posedge clk_i);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/drq_pkg.sv
src/drq_front.sv
src/drq_back.sv
src/delayed_release_queue.sv
verif/tb.sv
